/* hw/rtl/gb3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int CHANNELS  = 3;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = CHANNELS * CHAN_W;

  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // channel 0 (red) sits in the lowest bits, same as the stream word
  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_t;

  // one window column, rows from top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

`default_nettype wire

/* hw/rtl/gaussian_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none

// 3x3 binomial blur (1-2-1 / 2-4-2 / 1-2-1, rounded as (sum + 8) / 16) on each
// channel of an RGB pixel stream in raster order, with edge pixels replicated on
// all four borders. One word per clock is taken in while the output is not stalled
// and at most one word per clock comes out; the sustained rate of one word per cycle
// is set by the two line stores, each a MAX_WIDTH x 24 memory that does one read and
// one write per cycle. A result word passes the read stage, the lane sums and the
// output register, and the output trails the input by one row plus one pixel. After
// the last pixel of a frame the host sends frame_width + 1 drain words (tuser = 1)
// that push out the last results; the last result of a frame carries tlast and then
// the next pixel opens a new frame. Pixels beyond the frame and drain words that come
// early are dropped. A register write restarts the frame; the line stores need no
// clearing since each frame writes a line before reading it.
module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  wire logic [gb3_pkg::PIX_W-1:0]          s_axis_tdata,
  // action [0]
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic [gb3_pkg::PIX_W-1:0]               m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_write,
  input  wire logic [gb3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gb3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int ROW_W = gb3_pkg::HEIGHT_W + 1;

  typedef struct packed {
    logic pixel;
    logic row0;
    logic wr_en;
    logic emit;
    logic left_o2;
    logic right_new;
    logic last;
  } ctl_t;

  // configuration
  logic [gb3_pkg::WIDTH_W-1:0]  frame_width;
  logic [gb3_pkg::HEIGHT_W-1:0] frame_height;
  logic [AW-1:0]                last_col;
  logic [gb3_pkg::HEIGHT_W-1:0] last_row;
  logic                         width_one;

  // frame position of the input side and of the result side
  logic [AW-1:0]                col;
  logic [ROW_W-1:0]             row;
  logic [AW-1:0]                ecol;
  logic [gb3_pkg::HEIGHT_W-1:0] erow;
  logic [AW-1:0]                col_next;
  logic [ROW_W-1:0]             row_next;
  logic [AW-1:0]                ecol_next;
  logic [gb3_pkg::HEIGHT_W-1:0] erow_next;

  logic en;
  logic accept;
  logic drain;
  logic row_past;
  logic act;
  logic emit_ok;
  logic kind0;
  logic last;
  ctl_t ctl_in;

  // memory read stage
  logic          va;
  ctl_t          ctl_b;
  logic [AW-1:0] addr_b;
  gb3_pkg::pix_t pix_b;
  gb3_pkg::pix_t rd_upper;
  gb3_pkg::pix_t rd_middle;
  gb3_pkg::pix_t upper_wdata;
  logic          store_wr;

  // window and lane inputs
  gb3_pkg::col_t col_new;
  gb3_pkg::col_t win_o1;
  gb3_pkg::col_t win_o2;
  gb3_pkg::col_t left_sel;
  gb3_pkg::col_t right_sel;

  // lane stage
  logic          vc;
  logic          last_c;
  gb3_pkg::pix_t res_pix;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    if (frame_width == '0) begin
      last_col = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      last_col = AW'(MAX_WIDTH - 1);
    end else begin
      last_col = AW'(frame_width - 11'd1);
    end
  end

  assign width_one = (last_col == '0);
  assign last_row  = (frame_height == '0) ? '0 : frame_height - 16'd1;

  assign drain    = s_axis_tuser;
  assign row_past = row > {1'b0, last_row};
  assign act      = drain ? row_past : !row_past;
  assign emit_ok  = (row[ROW_W-1:1] != '0) || ((row == ROW_W'(1)) && (col != '0));
  // at column 0 the result closes the previous row, taken before the window shifts
  assign kind0    = (col == '0);
  assign last     = (ecol == last_col) && (erow == last_row);

  always_comb begin
    ctl_in.pixel     = !drain;
    ctl_in.row0      = (row == '0);
    ctl_in.wr_en     = !drain && !(kind0 && emit_ok && last);
    ctl_in.emit      = emit_ok;
    ctl_in.left_o2   = kind0 ? width_one : (col == AW'(1));
    ctl_in.right_new = !kind0;
    ctl_in.last      = last;
  end

  always_comb begin
    col_next  = (col == last_col) ? '0 : col + AW'(1);
    row_next  = (col == last_col) ? row + ROW_W'(1) : row;
    ecol_next = ecol;
    erow_next = erow;
    if (emit_ok) begin
      ecol_next = (ecol == last_col) ? '0 : ecol + AW'(1);
      erow_next = (ecol == last_col) ? erow + 16'd1 : erow;
    end
    if (emit_ok && last) begin
      col_next  = '0;
      row_next  = '0;
      ecol_next = '0;
      erow_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gb3_pkg::WIDTH_RESET;
      frame_height <= gb3_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      ecol         <= '0;
      erow         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gb3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[gb3_pkg::WIDTH_W-1:0];
        gb3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[gb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
      col  <= '0;
      row  <= '0;
      ecol <= '0;
      erow <= '0;
    end else if (accept && act) begin
      col  <= col_next;
      row  <= row_next;
      ecol <= ecol_next;
      erow <= erow_next;
    end
  end

  // dropped words never enter the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= accept && act;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_b  <= ctl_in;
      addr_b <= col;
      pix_b  <= gb3_pkg::pix_t'(s_axis_tdata);
    end
  end

  assign store_wr    = va && ctl_b.wr_en;
  assign upper_wdata = ctl_b.row0 ? pix_b : rd_middle;

  gb3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_upper (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .wr    (store_wr),
    .waddr (addr_b),
    .wdata (upper_wdata),
    .raddr (col),
    .rdata (rd_upper)
  );

  gb3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_middle (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .wr    (store_wr),
    .waddr (addr_b),
    .wdata (pix_b),
    .raddr (col),
    .rdata (rd_middle)
  );

  // first row stands in for the row above; drain words repeat the middle row below
  always_comb begin
    col_new.top = (ctl_b.pixel && ctl_b.row0) ? pix_b : rd_upper;
    col_new.mid = (ctl_b.pixel && ctl_b.row0) ? pix_b : rd_middle;
    col_new.bot = ctl_b.pixel ? pix_b : rd_middle;
  end

  always_ff @(posedge clk) begin
    if (en && va) begin
      win_o1 <= win_o2;
      win_o2 <= col_new;
    end
  end

  assign left_sel  = ctl_b.left_o2 ? win_o2 : win_o1;
  assign right_sel = ctl_b.right_new ? col_new : win_o2;

  for (genvar i = 0; i < gb3_pkg::CHANNELS; i++) begin : g_lane
    gb3_lane #(
      .LANE (i)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .left   (left_sel),
      .center (win_o2),
      .right  (right_sel),
      .result (res_pix[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vc            <= va && ctl_b.emit;
      m_axis_tvalid <= vc;
    end
  end

  // merge the lanes into the output word
  always_ff @(posedge clk) begin
    if (en) begin
      last_c       <= ctl_b.last;
      m_axis_tdata <= res_pix;
      m_axis_tlast <= last_c;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= last_col)
    else $error("column count beyond frame width");

  a_erow_range: assert property (@(posedge clk) disable iff (rst)
    erow <= last_row)
    else $error("result row beyond frame height");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && act && emit_ok && last) |=>
      (col == '0 && row == '0 && ecol == '0 && erow == '0))
    else $error("frame did not restart after its last result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (en && !va) |=> !vc)
    else $error("result stage filled without an item");

endmodule

`default_nettype wire

/* hw/rtl/gb3_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module gb3_line_store #(
  parameter int DEPTH = gb3_pkg::MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           wr,
  input  wire logic [AW-1:0]  waddr,
  input  wire gb3_pkg::pix_t  wdata,
  input  wire logic [AW-1:0]  raddr,
  output gb3_pkg::pix_t       rdata
);

  gb3_pkg::pix_t mem [DEPTH];
  gb3_pkg::pix_t mem_q;
  gb3_pkg::pix_t fwd_data;
  logic          fwd;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        mem[waddr] <= wdata;
      end
      mem_q <= mem[raddr];
    end
  end

  // a read that meets a write to the same entry takes the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (en) begin
      fwd <= wr && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd ? fwd_data : mem_q;

endmodule

`default_nettype wire

/* hw/rtl/gb3_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module gb3_lane #(
  parameter int LANE = 0
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire gb3_pkg::col_t                left,
  input  wire gb3_pkg::col_t                center,
  input  wire gb3_pkg::col_t                right,
  output logic [gb3_pkg::CHAN_W-1:0]        result
);

  localparam int VSUM_W  = gb3_pkg::CHAN_W + 2;
  localparam int TOTAL_W = gb3_pkg::CHAN_W + 4;

  logic [VSUM_W-1:0]  sum_left;
  logic [VSUM_W-1:0]  sum_center;
  logic [VSUM_W-1:0]  sum_right;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] rounded;

  // vertical 1-2-1 over one column
  function automatic logic [VSUM_W-1:0] vsum(input gb3_pkg::col_t col);
    vsum = {2'b00, col.top[LANE]} + {1'b0, col.mid[LANE], 1'b0} + {2'b00, col.bot[LANE]};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sum_left   <= vsum(left);
      sum_center <= vsum(center);
      sum_right  <= vsum(right);
    end
  end

  // horizontal 1-2-1, then round to nearest over the weight of 16
  assign total   = {2'b00, sum_left} + {1'b0, sum_center, 1'b0} + {2'b00, sum_right};
  assign rounded = total + TOTAL_W'(8);
  assign result  = rounded[TOTAL_W-1:4];

endmodule

`default_nettype wire

/* tb/sv/gaussian_blur_3x3_rgb_tb.sv */
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb_tb;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    gb3_pkg::pix_t px;
    logic closes;
  } blurred_t;

  localparam logic [gb3_pkg::PIX_W-1:0] EDGE_PX [12] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF,
    24'h000000, 24'hFFFFFF, 24'h010101, 24'hFEFEFE, 24'h7F807F, 24'hFFFFFF
  };

  // tracks line stores, window and frame counters; queues the blurred pixels due
  class blur_tracker;
    gb3_pkg::pix_t upper_row [gb3_pkg::MAX_WIDTH];
    gb3_pkg::pix_t middle_row [gb3_pkg::MAX_WIDTH];
    gb3_pkg::pix_t win [3][3];  // [column, 0 oldest][row, 0 top]
    int unsigned col_cnt, row_cnt, done_cnt;
    int unsigned width_reg, height_reg;
    int unsigned errors;
    blurred_t blurred_q[$];

    function new();
      for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      width_reg = gb3_pkg::WIDTH_RESET;
      height_reg = gb3_pkg::HEIGHT_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      col_cnt = 0;
      row_cnt = 0;
      done_cnt = 0;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          win[c][r] = '0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > gb3_pkg::MAX_WIDTH) return gb3_pkg::MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction

    function void set_reg(logic [gb3_pkg::CFG_INDEX_W-1:0] idx,
                          logic [gb3_pkg::CFG_DATA_W-1:0] value);
      if (idx == gb3_pkg::REG_FRAME_WIDTH) width_reg = value[gb3_pkg::WIDTH_W-1:0];
      else height_reg = value[gb3_pkg::HEIGHT_W-1:0];
      restart();
    endfunction

    function gb3_pkg::pix_t blur_at(input int unsigned lc, cc, rc);
      gb3_pkg::pix_t res;
      logic [31:0] total, rsum;
      for (int k = 0; k < gb3_pkg::CHANNELS; k++) begin
        total = 0;
        for (int r = 0; r < 3; r++) begin
          rsum = win[lc][r][k] + 2 * win[cc][r][k] + win[rc][r][k];
          total += (r == 1) ? 2 * rsum : rsum;
        end
        total = (total + 8) >> 4;
        res[k] = total[gb3_pkg::CHAN_W-1:0];
      end
      return res;
    endfunction

    // returns 1 when this pixel closes the frame
    function bit push_blurred(input int unsigned lc, cc, rc, w, h);
      blurred_t res;
      res.px = blur_at(lc, cc, rc);
      res.closes = (done_cnt + 1 == w * h);
      blurred_q.push_back(res);
      done_cnt = (done_cnt + 1) & 32'h03FF_FFFF;
      if (res.closes) restart();
      return res.closes;
    endfunction

    function void take_word(bit drain, gb3_pkg::pix_t px);
      int unsigned w, h, c, r, a;
      bit can_emit;
      gb3_pkg::pix_t top, mid, bot;
      w = eff_width();
      h = eff_height();
      c = col_cnt;
      r = row_cnt;
      a = (c >= w) ? 0 : c;
      // pixels past the frame and early drain words are dropped
      if (!drain && r >= h) return;
      if (drain && r < h) return;
      can_emit = (r >= 2) || (r == 1 && c >= 1);
      // first column of a row closes the right edge of the row before
      if (c == 0 && can_emit) begin
        if (push_blurred((w >= 2) ? 1 : 2, 2, 2, w, h)) return;
      end
      if (!drain) begin
        if (r == 0) begin
          top = px;
          mid = px;
          upper_row[a] = px;
        end else begin
          top = upper_row[a];
          mid = middle_row[a];
          upper_row[a] = mid;
        end
        bot = px;
        middle_row[a] = px;
      end else begin
        // bottom edge: middle row stands in for the missing row below
        top = upper_row[a];
        mid = middle_row[a];
        bot = mid;
      end
      win[0] = win[1];
      win[1] = win[2];
      win[2][0] = top;
      win[2][1] = mid;
      win[2][2] = bot;
      if (c >= 1 && can_emit) begin
        if (push_blurred((c == 1) ? 1 : 0, 1, 2, w, h)) return;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      if (errors < 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      errors++;
    endfunction

    function void check_pixel(gb3_pkg::pix_t px, logic closes);
      blurred_t want;
      if (blurred_q.size() == 0) begin
        flag("word with nothing pending", 0, px);
        return;
      end
      want = blurred_q.pop_front();
      for (int k = 0; k < gb3_pkg::CHANNELS; k++)
        if (px[k] !== want.px[k]) flag($sformatf("channel %0d", k), want.px[k], px[k]);
      if (closes !== want.closes) flag("tlast", want.closes, closes);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  logic [gb3_pkg::PIX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;            // action [0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // red_out [7:0], green_out [15:8], blue_out [23:16]
  logic [gb3_pkg::PIX_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_write = 1'b0;
  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  blur_tracker sb = new();

  gaussian_blur_3x3_rgb uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: check each accepted word, then pick next tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
    if (hold_armed && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic gb3_pkg::pix_t rand_pix();
    gb3_pkg::pix_t p;
    for (int k = 0; k < gb3_pkg::CHANNELS; k++)
      p[k] = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                      : 8'($urandom_range(255));
    return p;
  endfunction

  task automatic set_mode(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle = 0;
        recv_stall = 0;
      end
      IDLE_SEND: begin
        send_idle = 48;
        recv_stall = 0;
      end
      IDLE_RECV: begin
        send_idle = 0;
        recv_stall = 48;
      end
      default: begin
        send_idle = 32;
        recv_stall = 32;
      end
    endcase
  endtask

  task automatic send_word(input bit drain, input gb3_pkg::pix_t px);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= drain;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_word(drain, px);
  endtask

  // let every due word come out, then give the pipeline time to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gb3_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gb3_pkg::CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  initial begin
    int unsigned w_set, h_set, w_eff, h_eff, cut, real_items, frame_idx, sel;
    bit fresh;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: one row and ten pixels in, nine results out
    set_mode(IDLE_SEND);
    repeat (650) send_word(1'b0, rand_pix());
    settle();

    // small frame with extreme pixels, an early drain, a stray pixel and a late drain
    set_mode(IDLE_NONE);
    write_reg(gb3_pkg::REG_FRAME_WIDTH, 16'd4);
    write_reg(gb3_pkg::REG_FRAME_HEIGHT, 16'd3);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_word(1'b1, rand_pix());
      send_word(1'b0, EDGE_PX[i]);
    end
    send_word(1'b0, 24'hFFFFFF);
    repeat (5) send_word(1'b1, rand_pix());
    send_word(1'b1, rand_pix());
    settle();

    // zero width and height both act as one
    write_reg(gb3_pkg::REG_FRAME_WIDTH, 16'd0);
    write_reg(gb3_pkg::REG_FRAME_HEIGHT, 16'd0);
    send_word(1'b0, 24'h808080);
    repeat (2) send_word(1'b1, rand_pix());
    settle();

    // random frames; the receiver holds off for a while at the start
    hold_armed = 1'b1;
    real_items = 0;
    frame_idx = 0;
    fresh = 1'b1;
    while (real_items < 350) begin
      set_mode(idle_mode_t'(frame_idx % 4));
      if (fresh || $urandom_range(3) == 0) begin
        settle();
        sel = $urandom_range(19);
        w_set = (sel < 14) ? $urandom_range(1, 8) :
                (sel < 19) ? $urandom_range(9, 40) : $urandom_range(41, 160);
        h_set = (w_set > 40) ? $urandom_range(1, 2) :
                ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
        if ($urandom_range(15) == 0) w_set = 0;
        if ($urandom_range(15) == 0) h_set = 0;
        // upper bits of a width write are don't-care
        write_reg(gb3_pkg::REG_FRAME_WIDTH, {5'($urandom_range(31)), 11'(w_set)});
        write_reg(gb3_pkg::REG_FRAME_HEIGHT, 16'(h_set));
      end
      w_eff = sb.eff_width();
      h_eff = sb.eff_height();
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, w_eff * h_eff) : 0;
      for (int unsigned i = 0; i < w_eff * h_eff; i++) begin
        if ($urandom_range(19) == 0) send_word(1'b1, rand_pix());
        send_word(1'b0, rand_pix());
        real_items++;
        if (cut != 0 && i + 1 == cut) break;
      end
      if (cut != 0) begin
        fresh = 1'b1;
      end else begin
        if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_word(1'b0, rand_pix());
        repeat (w_eff + 1) send_word(1'b1, rand_pix());
        real_items += w_eff + 1;
        if ($urandom_range(5) == 0) send_word(1'b1, rand_pix());
        fresh = 1'b0;
      end
      frame_idx++;
    end

    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
